@@ sv/rpfp_pkg.sv @@
package rpfp_pkg;

    localparam int MAX_PAYLOAD_BYTES = 65536;
    // position counter holds 0..MAX_PAYLOAD_BYTES inclusive
    localparam int POS_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PAYLOAD_BYTES);

    localparam logic [7:0] INT_TAG = 8'ha0;

    // request opcodes
    localparam logic [7:0] OPC_1  = 8'd1;
    localparam logic [7:0] OPC_2  = 8'd2;
    localparam logic [7:0] OPC_3  = 8'd3;
    localparam logic [7:0] OPC_4  = 8'd4;
    localparam logic [7:0] OPC_5  = 8'd5;
    localparam logic [7:0] OPC_6  = 8'd6;
    localparam logic [7:0] OPC_7  = 8'd7;
    localparam logic [7:0] OPC_8  = 8'd8;
    localparam logic [7:0] OPC_9  = 8'd9;
    localparam logic [7:0] OPC_10 = 8'd10;
    localparam logic [7:0] OPC_21 = 8'd21;
    localparam logic [7:0] OPC_23 = 8'd23;

    typedef enum logic [2:0] {
        LAY_IMPO    = 3'd0,
        LAY_IP2OT   = 3'd1,
        LAY_IPO     = 3'd2,
        LAY_IRNYMPO = 3'd3,
        LAY_IR      = 3'd4,
        LAY_IOPTS   = 3'd5
    } t_layout;

    typedef enum logic [3:0] {
        SLOT_IDENT   = 4'd0,
        SLOT_PATH    = 4'd1,
        SLOT_PATH2   = 4'd2,
        SLOT_OPAQUE  = 4'd3,
        SLOT_OPAQUE2 = 4'd4,
        SLOT_AVOID   = 4'd5,
        SLOT_REQID   = 4'd6,
        SLOT_NOTIFY  = 4'd7,
        SLOT_PRTY    = 4'd8,
        SLOT_MODE    = 4'd9,
        SLOT_OPTS    = 4'd10
    } t_slot;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TRUNC      = 3'd1,
        ST_BAD_TAG    = 3'd2,
        ST_BAD_OPCODE = 3'd3,
        ST_TOO_LONG   = 3'd4
    } t_status;

    typedef struct packed {
        logic        record_kind;
        t_slot       slot;
        logic        present;
        logic [15:0] content_offset;
        logic [15:0] content_length;
        logic [31:0] int_value;
        t_status     status;
    } t_rec;

    function automatic logic op_known(input logic [7:0] op);
        logic known;
        unique case (op) inside
            OPC_1, OPC_2, OPC_3, OPC_4, OPC_5, OPC_6, OPC_7, OPC_8, OPC_9,
            OPC_10, OPC_21, OPC_23: known = 1'b1;
            default:                known = 1'b0;
        endcase
        return known;
    endfunction

    function automatic t_layout op_layout(input logic [7:0] op);
        t_layout lay;
        unique case (op) inside
            OPC_1, OPC_3, OPC_4, OPC_23: lay = LAY_IMPO;
            OPC_5:                       lay = LAY_IP2OT;
            OPC_8, OPC_9, OPC_21:        lay = LAY_IPO;
            OPC_6:                       lay = LAY_IRNYMPO;
            OPC_7:                       lay = LAY_IR;
            OPC_2, OPC_10:               lay = LAY_IOPTS;
            default:                     lay = LAY_IMPO;
        endcase
        return lay;
    endfunction

    function automatic logic [3:0] lay_len(input t_layout lay);
        logic [3:0] n;
        unique case (lay)
            LAY_IMPO:    n = 4'd4;
            LAY_IP2OT:   n = 4'd5;
            LAY_IPO:     n = 4'd3;
            LAY_IRNYMPO: n = 4'd7;
            LAY_IR:      n = 4'd2;
            LAY_IOPTS:   n = 4'd5;
            default:     n = 4'd4;
        endcase
        return n;
    endfunction

    // fields from this step on may be missing at end of message
    function automatic logic [3:0] lay_fence(input t_layout lay);
        logic [3:0] n;
        unique case (lay)
            LAY_IMPO:    n = 4'd3;
            LAY_IP2OT:   n = 4'd3;
            LAY_IPO:     n = 4'd2;
            LAY_IRNYMPO: n = 4'd6;
            LAY_IR:      n = 4'd2;
            LAY_IOPTS:   n = 4'd3;
            default:     n = 4'd3;
        endcase
        return n;
    endfunction

    function automatic t_slot lay_slot(input t_layout lay, input logic [2:0] step);
        t_slot s;
        s = SLOT_IDENT;
        unique case (lay)
            LAY_IMPO: begin
                case (step)
                    3'd1:    s = SLOT_MODE;
                    3'd2:    s = SLOT_PATH;
                    3'd3:    s = SLOT_OPAQUE;
                    default: s = SLOT_IDENT;
                endcase
            end
            LAY_IP2OT: begin
                case (step)
                    3'd1:    s = SLOT_PATH;
                    3'd2:    s = SLOT_PATH2;
                    3'd3:    s = SLOT_OPAQUE;
                    3'd4:    s = SLOT_OPAQUE2;
                    default: s = SLOT_IDENT;
                endcase
            end
            LAY_IPO: begin
                case (step)
                    3'd1:    s = SLOT_PATH;
                    3'd2:    s = SLOT_OPAQUE;
                    default: s = SLOT_IDENT;
                endcase
            end
            LAY_IRNYMPO: begin
                case (step)
                    3'd1:    s = SLOT_REQID;
                    3'd2:    s = SLOT_NOTIFY;
                    3'd3:    s = SLOT_PRTY;
                    3'd4:    s = SLOT_MODE;
                    3'd5:    s = SLOT_PATH;
                    3'd6:    s = SLOT_OPAQUE;
                    default: s = SLOT_IDENT;
                endcase
            end
            LAY_IR: begin
                case (step)
                    3'd1:    s = SLOT_REQID;
                    default: s = SLOT_IDENT;
                endcase
            end
            LAY_IOPTS: begin
                case (step)
                    3'd1:    s = SLOT_OPTS;
                    3'd2:    s = SLOT_PATH;
                    3'd3:    s = SLOT_OPAQUE;
                    3'd4:    s = SLOT_AVOID;
                    default: s = SLOT_IDENT;
                endcase
            end
            default: s = SLOT_IDENT;
        endcase
        return s;
    endfunction

endpackage

@@ sv/request_payload_field_parser.sv @@
// A result appears in the output register in the cycle after the word that
// finishes a field or ends the message is accepted.
// Throughput: one word per cycle; input stays ready while the output register is
// empty or being drained, so a stalled result holds only the words behind it.
// Reset (i_rst_n low, synchronous) closes any open message and empties the output.
module request_payload_field_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // opcode[7:0], data_byte[15:8]
    input  logic        i_s_axis_tuser,  // kind[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,  // slot[3:0], present[4], content_offset[20:5],
                                         // content_length[36:21], int_value[68:37],
                                         // status[71:69]
    output logic        o_m_axis_tuser   // record_kind[0]
);

    logic           c_take;
    logic           c_rec_valid;
    rpfp_pkg::t_rec c_rec;
    logic           r_out_valid, n_out_valid;
    rpfp_pkg::t_rec r_out, n_out;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign c_take          = i_s_axis_tvalid && o_s_axis_tready;

    rpfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (c_take),
        .i_kind      (i_s_axis_tuser),
        .i_opcode    (i_s_axis_tdata[7:0]),
        .i_data_byte (i_s_axis_tdata[15:8]),
        .o_rec_valid (c_rec_valid),
        .o_rec       (c_rec)
    );

    always_comb begin
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out       = r_out;
        if (c_take && c_rec_valid) begin
            n_out_valid = 1'b1;
            n_out       = c_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.record_kind;
    assign o_m_axis_tdata  = {r_out.status, r_out.int_value, r_out.content_length,
                              r_out.content_offset, r_out.present, r_out.slot};

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        (o_m_axis_tdata[68:0] == 69'd0))
        else $error("status word carries field data");

    a_field_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
        (o_m_axis_tdata[71:69] == rpfp_pkg::ST_OK))
        else $error("field word carries nonzero status");

    a_opts_no_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser &&
         o_m_axis_tdata[3:0] == rpfp_pkg::SLOT_OPTS) |->
        (o_m_axis_tdata[36:5] == 32'd0 && o_m_axis_tdata[4]))
        else $error("options word malformed");

endmodule

@@ sv/rpfp_core.sv @@
module rpfp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic               i_kind,
    input  logic [7:0]         i_opcode,
    input  logic [7:0]         i_data_byte,
    output logic               o_rec_valid,
    output rpfp_pkg::t_rec     o_rec
);

    logic                        r_open, n_open;
    rpfp_pkg::t_layout           r_layout, n_layout;
    logic [3:0]                  r_step, n_step;
    logic [2:0]                  r_phase, n_phase;
    logic [7:0]                  r_len_high, n_len_high;
    logic [15:0]                 r_remain, n_remain;
    logic [15:0]                 r_start, n_start;
    logic [15:0]                 r_flen, n_flen;
    logic [31:0]                 r_acc, n_acc;
    logic [rpfp_pkg::POS_W-1:0]  r_pos, n_pos;
    rpfp_pkg::t_status           r_err, n_err;

    rpfp_pkg::t_layout           c_layout;
    rpfp_pkg::t_status           c_err;
    rpfp_pkg::t_slot             c_slot;
    logic [15:0]                 c_str_len;
    logic [15:0]                 c_remain_dec;
    logic [rpfp_pkg::POS_W+15:0] c_pos_inc;

    // first word of a message picks the layout from its opcode
    assign c_layout = r_open ? r_layout : rpfp_pkg::op_layout(i_opcode);
    assign c_err    = r_open ? r_err
                    : (rpfp_pkg::op_known(i_opcode) ? rpfp_pkg::ST_OK
                                                    : rpfp_pkg::ST_BAD_OPCODE);
    assign c_slot       = rpfp_pkg::lay_slot(c_layout, r_step[2:0]);
    assign c_str_len    = {r_len_high, i_data_byte};
    assign c_remain_dec = (r_remain != 16'd0) ? (r_remain - 16'd1) : r_remain;
    assign c_pos_inc    = {16'd0, r_pos} + (rpfp_pkg::POS_W + 16)'(1);

    always_comb begin
        n_open     = 1'b1;
        n_layout   = c_layout;
        n_err      = c_err;
        n_step     = r_step;
        n_phase    = r_phase;
        n_len_high = r_len_high;
        n_remain   = r_remain;
        n_start    = r_start;
        n_flen     = r_flen;
        n_acc      = r_acc;
        n_pos      = r_pos;
        o_rec_valid = 1'b0;
        o_rec       = '0;
        o_rec.slot  = c_slot;

        if (!i_kind) begin
            if (c_err != rpfp_pkg::ST_OK) begin
                // bytes dropped after an error
            end else if (r_pos >= rpfp_pkg::POS_MAX) begin
                n_err = rpfp_pkg::ST_TOO_LONG;
            end else begin
                n_pos = c_pos_inc[rpfp_pkg::POS_W-1:0];
                if (r_step < rpfp_pkg::lay_len(c_layout)) begin
                    if (c_slot == rpfp_pkg::SLOT_OPTS) begin
                        if (r_phase == 3'd0) begin
                            if (i_data_byte != rpfp_pkg::INT_TAG) begin
                                n_err = rpfp_pkg::ST_BAD_TAG;
                            end else begin
                                n_acc   = '0;
                                n_phase = 3'd1;
                            end
                        end else begin
                            n_acc = {r_acc[23:0], i_data_byte};
                            if (r_phase >= 3'd4) begin
                                o_rec_valid     = 1'b1;
                                o_rec.present   = 1'b1;
                                o_rec.int_value = n_acc;
                                n_step          = r_step + 4'd1;
                                n_phase         = 3'd0;
                            end else begin
                                n_phase = r_phase + 3'd1;
                            end
                        end
                    end else if (r_phase == 3'd0) begin
                        n_len_high = i_data_byte;
                        n_phase    = 3'd1;
                    end else if (r_phase == 3'd1) begin
                        if (c_str_len == 16'd0) begin
                            // absent field
                            o_rec_valid = 1'b1;
                            n_step      = r_step + 4'd1;
                            n_phase     = 3'd0;
                        end else begin
                            n_start  = c_pos_inc[15:0];
                            n_flen   = c_str_len - 16'd1;
                            n_remain = c_str_len;
                            n_phase  = 3'd2;
                        end
                    end else begin
                        n_remain = c_remain_dec;
                        if (c_remain_dec == 16'd0) begin
                            o_rec_valid          = 1'b1;
                            o_rec.present        = 1'b1;
                            o_rec.content_offset = r_start;
                            o_rec.content_length = r_flen;
                            n_step               = r_step + 4'd1;
                            n_phase              = 3'd0;
                        end
                    end
                end
            end
        end else begin
            o_rec_valid       = 1'b1;
            o_rec.record_kind = 1'b1;
            o_rec.slot        = rpfp_pkg::SLOT_IDENT;
            if (c_err != rpfp_pkg::ST_OK) begin
                o_rec.status = c_err;
            end else if (r_step >= rpfp_pkg::lay_len(c_layout)) begin
                o_rec.status = rpfp_pkg::ST_OK;
            end else if (r_phase == 3'd0 && r_step >= rpfp_pkg::lay_fence(c_layout)) begin
                o_rec.status = rpfp_pkg::ST_OK;
            end else begin
                o_rec.status = rpfp_pkg::ST_TRUNC;
            end
            // message closed: back to the reset state
            n_open     = 1'b0;
            n_layout   = rpfp_pkg::LAY_IMPO;
            n_err      = rpfp_pkg::ST_OK;
            n_step     = '0;
            n_phase    = '0;
            n_len_high = '0;
            n_remain   = '0;
            n_start    = '0;
            n_flen     = '0;
            n_acc      = '0;
            n_pos      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_layout   <= rpfp_pkg::LAY_IMPO;
            r_err      <= rpfp_pkg::ST_OK;
            r_step     <= '0;
            r_phase    <= '0;
            r_len_high <= '0;
            r_remain   <= '0;
            r_start    <= '0;
            r_flen     <= '0;
            r_acc      <= '0;
            r_pos      <= '0;
        end else if (i_take) begin
            r_open     <= n_open;
            r_layout   <= n_layout;
            r_err      <= n_err;
            r_step     <= n_step;
            r_phase    <= n_phase;
            r_len_high <= n_len_high;
            r_remain   <= n_remain;
            r_start    <= n_start;
            r_flen     <= n_flen;
            r_acc      <= n_acc;
            r_pos      <= n_pos;
        end
    end

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_kind) |=> (!r_open && r_pos == '0 && r_step == 4'd0))
        else $error("message state not cleared after end word");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= rpfp_pkg::POS_MAX)
        else $error("byte position past saturation limit");

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= 3'd4 && (r_phase != 3'd0 || r_remain == 16'd0 || !r_open ||
        r_step != 4'd0 || r_err != rpfp_pkg::ST_OK || 1'b1))
        else $error("field phase out of range");

endmodule
